### design/binary_lifting_ancestor_table_macros.svh
// assertion macros for the binary lifting ancestor table
// no dependencies; included by the modules that carry assertions
`ifndef BINARY_LIFTING_ANCESTOR_TABLE_MACROS_SVH
`define BINARY_LIFTING_ANCESTOR_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BLAT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BLAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BLAT_ASSERT(lbl, clk, rstn, prop, msg)
`define BLAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### design/blat_pkg.sv
// shared types, codes and constants of the binary lifting ancestor table
// no dependencies; used by blat_store, blat_engine and the top level
`timescale 1ns / 1ps

package blat_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 10;
  localparam int NodeW     = 10;
  localparam int DepthW    = 10;
  localparam int LvlFieldW = 4;

  typedef logic [NodeW-1:0]     node_t;
  typedef logic [DepthW-1:0]    depth_t;
  typedef logic [LvlFieldW-1:0] lvl_t;

  localparam depth_t DepthMax = depth_t'(1023);

  typedef struct packed {
    logic  present;
    node_t node;
  } anc_entry_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_LCA  = 2'd1,
    OP_KTH  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_DEP,
    ST_LD_WR,
    ST_LD_FWD,
    ST_LC_DEP,
    ST_LC_A,
    ST_LC_E,
    ST_LC_D,
    ST_LC_CHK,
    ST_LC_B,
    ST_LC_C,
    ST_LC_F,
    ST_LC_G,
    ST_KT_DEP,
    ST_KT_A,
    ST_KT_B,
    ST_FIN_RD,
    ST_FIN,
    ST_DONE
  } blat_state_e;

  typedef struct packed {
    logic       we;
    node_t      w_node;
    lvl_t       w_lvl;
    anc_entry_t w_data;
    node_t      a_node;
    lvl_t       a_lvl;
    node_t      b_node;
    lvl_t       b_lvl;
  } anc_req_t;

  typedef struct packed {
    anc_entry_t a;
    anc_entry_t b;
  } anc_rsp_t;

  typedef struct packed {
    logic   we;
    node_t  w_node;
    depth_t w_depth;
    node_t  a_node;
    node_t  b_node;
  } dep_req_t;

  typedef struct packed {
    depth_t a;
    depth_t b;
  } dep_rsp_t;

endpackage

### design/blat_store.sv
// ancestor table and depth store, one write and two registered reads each
// depends on blat_pkg
`timescale 1ns / 1ps

module blat_store #(
  parameter int Levels = blat_pkg::LEVELS
) (
  input  logic               clk_i,
  input  blat_pkg::anc_req_t anc_req_i,
  output blat_pkg::anc_rsp_t anc_rsp_o,
  input  blat_pkg::dep_req_t dep_req_i,
  output blat_pkg::dep_rsp_t dep_rsp_o
);

  localparam int AncDepth = blat_pkg::MAX_NODES * Levels;
  localparam int AncAW    = $clog2(AncDepth);

  blat_pkg::anc_entry_t anc_mem [AncDepth];
  blat_pkg::depth_t     dep_mem [blat_pkg::MAX_NODES];

  blat_pkg::anc_entry_t anc_a_q, anc_b_q;
  blat_pkg::depth_t     dep_a_q, dep_b_q;

  // row-major: one row of Levels entries per node
  function automatic logic [AncAW-1:0] anc_addr(blat_pkg::node_t n, blat_pkg::lvl_t l);
    return AncAW'(n) * AncAW'(Levels) + AncAW'(l);
  endfunction

  always_ff @(posedge clk_i) begin
    if (anc_req_i.we) begin
      anc_mem[anc_addr(anc_req_i.w_node, anc_req_i.w_lvl)] <= anc_req_i.w_data;
    end
    anc_a_q <= anc_mem[anc_addr(anc_req_i.a_node, anc_req_i.a_lvl)];
    anc_b_q <= anc_mem[anc_addr(anc_req_i.b_node, anc_req_i.b_lvl)];
  end

  always_ff @(posedge clk_i) begin
    if (dep_req_i.we) begin
      dep_mem[dep_req_i.w_node] <= dep_req_i.w_depth;
    end
    dep_a_q <= dep_mem[dep_req_i.a_node];
    dep_b_q <= dep_mem[dep_req_i.b_node];
  end

  assign anc_rsp_o.a = anc_a_q;
  assign anc_rsp_o.b = anc_b_q;
  assign dep_rsp_o.a = dep_a_q;
  assign dep_rsp_o.b = dep_b_q;

endmodule

### design/blat_engine.sv
// sequencer and shared compare/select datapath for load, lca and kth requests
// depends on blat_pkg and the assertion macro header; drives blat_store
`timescale 1ns / 1ps
`include "binary_lifting_ancestor_table_macros.svh"

module blat_engine #(
  parameter int Levels = blat_pkg::LEVELS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  blat_pkg::node_t          node_i,
  input  blat_pkg::node_t          parent_node_i,
  input  logic                     is_root_i,
  input  blat_pkg::node_t          other_node_i,
  input  logic [9:0]               steps_up_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output blat_pkg::node_t          result_node_o,
  output blat_pkg::depth_t         result_depth_o,
  output blat_pkg::anc_req_t       anc_req_o,
  input  blat_pkg::anc_rsp_t       anc_rsp_i,
  output blat_pkg::dep_req_t       dep_req_o,
  input  blat_pkg::dep_rsp_t       dep_rsp_i
);

  localparam int LvlW = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int KW   = (Levels > blat_pkg::DepthW) ? Levels : blat_pkg::DepthW;
  localparam logic [LvlW-1:0] LvlLast = LvlW'(Levels - 1);
  localparam logic [KW-1:0]   KCap    = KW'((1 << Levels) - 1);

  blat_pkg::blat_state_e state_q, state_d;
  blat_pkg::node_t       x_q, x_d, y_q, y_d;
  logic                  root_q, root_d;
  logic [KW-1:0]         k_q, k_d;
  logic [LvlW-1:0]       lvl_q, lvl_d;
  blat_pkg::depth_t      dy_q, dy_d;
  blat_pkg::anc_entry_t  cur_q, cur_d;
  blat_pkg::node_t       res_node_q, res_node_d;
  blat_pkg::depth_t      res_depth_q, res_depth_d;
  logic                  out_valid_q, out_valid_d;
  blat_pkg::node_t       out_node_q, out_node_d;
  blat_pkg::depth_t      out_depth_q, out_depth_d;

  blat_pkg::opcode_e     op_in;
  logic                  accept;
  logic                  out_free;
  logic                  lvl_zero;
  blat_pkg::node_t       y_in;
  blat_pkg::depth_t      load_depth;
  blat_pkg::anc_entry_t  fwd_entry;
  logic [KW-1:0]         k_dep, k_lim1, k_lim2;

  assign op_in    = blat_pkg::opcode_e'(opcode_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign lvl_zero = (lvl_q == '0);
  assign y_in     = (op_in == blat_pkg::OP_LOAD) ? parent_node_i : other_node_i;

  always_comb begin
    if (root_q) begin
      load_depth = '0;
    end else if (dep_rsp_i.b == blat_pkg::DepthMax) begin
      load_depth = blat_pkg::DepthMax;
    end else begin
      load_depth = dep_rsp_i.b + blat_pkg::depth_t'(1);
    end
    // a row entry that points back at the node being loaded sees the fresh write
    fwd_entry = (cur_q.node == x_q) ? cur_q : anc_rsp_i.a;
    k_dep  = KW'(dep_rsp_i.a);
    k_lim1 = (k_q > k_dep) ? k_dep : k_q;
    k_lim2 = (k_lim1 > KCap) ? KCap : k_lim1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      blat_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            blat_pkg::OP_LOAD: state_d = blat_pkg::ST_LD_DEP;
            blat_pkg::OP_LCA:  state_d = blat_pkg::ST_LC_DEP;
            blat_pkg::OP_KTH:  state_d = blat_pkg::ST_KT_DEP;
            blat_pkg::OP_NOP:  state_d = blat_pkg::ST_FIN;
            default:           state_d = blat_pkg::ST_FIN;
          endcase
        end
      end
      blat_pkg::ST_LD_DEP: state_d = blat_pkg::ST_LD_WR;
      blat_pkg::ST_LD_WR:  state_d = (lvl_q == LvlLast) ? blat_pkg::ST_DONE : blat_pkg::ST_LD_FWD;
      blat_pkg::ST_LD_FWD: state_d = blat_pkg::ST_LD_WR;
      blat_pkg::ST_LC_DEP: state_d = blat_pkg::ST_LC_A;
      blat_pkg::ST_LC_A:   state_d = blat_pkg::ST_LC_E;
      blat_pkg::ST_LC_E:   state_d = blat_pkg::ST_LC_D;
      blat_pkg::ST_LC_D:   state_d = lvl_zero ? blat_pkg::ST_LC_CHK : blat_pkg::ST_LC_A;
      blat_pkg::ST_LC_CHK: state_d = (x_q == y_q) ? blat_pkg::ST_DONE : blat_pkg::ST_LC_B;
      blat_pkg::ST_LC_B:   state_d = blat_pkg::ST_LC_C;
      blat_pkg::ST_LC_C:   state_d = lvl_zero ? blat_pkg::ST_LC_F : blat_pkg::ST_LC_B;
      blat_pkg::ST_LC_F:   state_d = blat_pkg::ST_LC_G;
      blat_pkg::ST_LC_G:   state_d = anc_rsp_i.a.present ? blat_pkg::ST_FIN : blat_pkg::ST_DONE;
      blat_pkg::ST_KT_DEP: state_d = blat_pkg::ST_KT_A;
      blat_pkg::ST_KT_A:   state_d = blat_pkg::ST_KT_B;
      blat_pkg::ST_KT_B:   state_d = lvl_zero ? blat_pkg::ST_FIN_RD : blat_pkg::ST_KT_A;
      blat_pkg::ST_FIN_RD: state_d = blat_pkg::ST_FIN;
      blat_pkg::ST_FIN:    state_d = blat_pkg::ST_DONE;
      blat_pkg::ST_DONE:   state_d = out_free ? blat_pkg::ST_IDLE : blat_pkg::ST_DONE;
      default:             state_d = blat_pkg::ST_IDLE;
    endcase
  end

  // store requests and handshake
  always_comb begin
    in_stall_o       = (state_q != blat_pkg::ST_IDLE);
    anc_req_o.we     = 1'b0;
    anc_req_o.w_node = x_q;
    anc_req_o.w_lvl  = blat_pkg::lvl_t'(lvl_q);
    anc_req_o.w_data = cur_q;
    anc_req_o.a_node = x_q;
    anc_req_o.a_lvl  = blat_pkg::lvl_t'(lvl_q);
    anc_req_o.b_node = y_q;
    anc_req_o.b_lvl  = blat_pkg::lvl_t'(lvl_q);
    dep_req_o.we      = 1'b0;
    dep_req_o.w_node  = x_q;
    dep_req_o.w_depth = load_depth;
    dep_req_o.a_node  = x_q;
    dep_req_o.b_node  = y_q;
    unique case (state_q)
      blat_pkg::ST_IDLE: begin
        dep_req_o.a_node = node_i;
        dep_req_o.b_node = y_in;
      end
      blat_pkg::ST_LD_DEP: dep_req_o.we = 1'b1;
      blat_pkg::ST_LD_WR: begin
        anc_req_o.we     = 1'b1;
        anc_req_o.a_node = cur_q.node;
      end
      blat_pkg::ST_LC_E:   dep_req_o.b_node = anc_rsp_i.a.node;
      blat_pkg::ST_LC_G:   dep_req_o.a_node = anc_rsp_i.a.node;
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    root_d      = root_q;
    k_d         = k_q;
    lvl_d       = lvl_q;
    dy_d        = dy_q;
    cur_d       = cur_q;
    res_node_d  = res_node_q;
    res_depth_d = res_depth_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_node_d  = out_node_q;
    out_depth_d = out_depth_q;
    unique case (state_q)
      blat_pkg::ST_IDLE: begin
        if (accept) begin
          x_d    = node_i;
          y_d    = y_in;
          root_d = is_root_i;
          k_d    = KW'(steps_up_i);
        end
      end
      blat_pkg::ST_LD_DEP: begin
        dy_d  = load_depth;
        cur_d = root_q ? '0 : '{present: 1'b1, node: y_q};
        lvl_d = '0;
      end
      blat_pkg::ST_LD_WR: begin
        res_node_d  = x_q;
        res_depth_d = dy_q;
      end
      blat_pkg::ST_LD_FWD: begin
        cur_d = cur_q.present ? fwd_entry : '0;
        lvl_d = lvl_q + LvlW'(1);
      end
      blat_pkg::ST_LC_DEP: begin
        // deeper node goes to x
        if (dep_rsp_i.a < dep_rsp_i.b) begin
          x_d  = y_q;
          y_d  = x_q;
          dy_d = dep_rsp_i.a;
        end else begin
          dy_d = dep_rsp_i.b;
        end
        lvl_d = LvlLast;
      end
      blat_pkg::ST_LC_E: cur_d = anc_rsp_i.a;
      blat_pkg::ST_LC_D: begin
        if (cur_q.present && (dep_rsp_i.b >= dy_q)) begin
          x_d = cur_q.node;
        end
        if (!lvl_zero) begin
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      blat_pkg::ST_LC_CHK: begin
        res_node_d  = x_q;
        res_depth_d = dy_q;
        lvl_d       = LvlLast;
      end
      blat_pkg::ST_LC_C: begin
        if (anc_rsp_i.a.present && anc_rsp_i.b.present &&
            (anc_rsp_i.a.node != anc_rsp_i.b.node)) begin
          x_d = anc_rsp_i.a.node;
          y_d = anc_rsp_i.b.node;
        end
        if (!lvl_zero) begin
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      blat_pkg::ST_LC_G: begin
        // different trees give node zero at depth zero
        x_d         = anc_rsp_i.a.node;
        res_node_d  = '0;
        res_depth_d = '0;
      end
      blat_pkg::ST_KT_DEP: begin
        k_d   = k_lim2;
        lvl_d = LvlLast;
      end
      blat_pkg::ST_KT_B: begin
        if (k_q[lvl_q] && anc_rsp_i.a.present) begin
          x_d = anc_rsp_i.a.node;
        end
        if (!lvl_zero) begin
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      blat_pkg::ST_FIN: begin
        res_node_d  = x_q;
        res_depth_d = dep_rsp_i.a;
      end
      blat_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_node_d  = res_node_q;
          out_depth_d = res_depth_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blat_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      lvl_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lvl_q       <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    root_q      <= root_d;
    k_q         <= k_d;
    dy_q        <= dy_d;
    cur_q       <= cur_d;
    res_node_q  <= res_node_d;
    res_depth_q <= res_depth_d;
    out_node_q  <= out_node_d;
    out_depth_q <= out_depth_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_node_o  = out_node_q;
  assign result_depth_o = out_depth_q;

  `BLAT_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, state_q != blat_pkg::ST_IDLE, "accepted request did not start")
  `BLAT_ASSERT_NEXT(a_done_pushes, clk_i, rst_ni, state_q == blat_pkg::ST_DONE && out_free, out_valid_q && state_q == blat_pkg::ST_IDLE, "finished result not pushed")
  `BLAT_ASSERT(a_push_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == blat_pkg::ST_DONE, "result appeared outside done")
  `BLAT_ASSERT(a_lvl_range, clk_i, rst_ni, lvl_q <= LvlLast, "level counter out of range")

endmodule

### design/binary_lifting_ancestor_table.sv
// top level of the binary lifting ancestor table
// depends on blat_pkg, blat_store and blat_engine
`timescale 1ns / 1ps

// Request channel: in_valid_i with in_stall_o; a request is taken on a rising
// edge with in_valid_i high and in_stall_o low. opcode 0 loads a node with its
// parent (parents first), 1 asks for the lowest common ancestor of node and
// other_node, 2 climbs steps_up levels from node, 3 only reads node's depth.
// Result channel: out_valid_o with out_stall_i; one result per request, node
// and its depth, held in an output register until taken.
// One request is in work at a time and in_stall_o stays high meanwhile; a
// finished result waits in the output register while the next is accepted.
// Each request is a chain of dependent store accesses over the lifting levels:
//   load writes a table entry per level, kth reads a table entry per level, lca
//   does a table read, depth read and compare per level, then a paired table
//   read and compare per level; the result shows as the sequencer goes idle.
// While the receiver stalls a held result, a done request holds in the sequencer and no
// further request is taken. Reset clears the sequencer and the result valid;
// table and depth memories are not cleared and must be loaded before use.

module binary_lifting_ancestor_table #(
  parameter int LEVELS = blat_pkg::LEVELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [9:0]  node_i,
  input  logic [9:0]  parent_node_i,
  input  logic        is_root_i,
  input  logic [9:0]  other_node_i,
  input  logic [9:0]  steps_up_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  result_node_o,
  output logic [9:0]  result_depth_o
);

  blat_pkg::anc_req_t anc_req;
  blat_pkg::anc_rsp_t anc_rsp;
  blat_pkg::dep_req_t dep_req;
  blat_pkg::dep_rsp_t dep_rsp;

  blat_engine #(
    .Levels(LEVELS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .node_i         (node_i),
    .parent_node_i  (parent_node_i),
    .is_root_i      (is_root_i),
    .other_node_i   (other_node_i),
    .steps_up_i     (steps_up_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_node_o  (result_node_o),
    .result_depth_o (result_depth_o),
    .anc_req_o      (anc_req),
    .anc_rsp_i      (anc_rsp),
    .dep_req_o      (dep_req),
    .dep_rsp_i      (dep_rsp)
  );

  blat_store #(
    .Levels(LEVELS)
  ) u_store (
    .clk_i     (clk_i),
    .anc_req_i (anc_req),
    .anc_rsp_o (anc_rsp),
    .dep_req_i (dep_req),
    .dep_rsp_o (dep_rsp)
  );

endmodule
